// ===== design/eiphp_pkg.sv =====
// ----------------------------------------------------------------------------
// eiphp_pkg
// Shared types, protocol constants and ones'-complement helpers for the
// Ethernet / IPv4 header parser.
// ----------------------------------------------------------------------------
package eiphp_pkg;

    typedef logic [16:0] pos_t;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [7:0]  ip_protocol;
        logic [5:0]  ip_header_bytes;
        logic        ip_checksum_ok;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  tcp_flags;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
        logic [15:0] window_size;
        logic        tcp_checksum_ok;
        logic [15:0] type_code;
    } eiphp_result_t;

    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP = 8'h01;
    localparam logic [7:0]  PROTO_TCP  = 8'h06;
    localparam logic [7:0]  PROTO_UDP  = 8'h11;
    localparam logic [3:0]  IHL_MASK   = 4'hF;

    localparam logic [1:0] KIND_ARP     = 2'd0;
    localparam logic [1:0] KIND_IPV4    = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // frame byte positions
    localparam pos_t OFS_TYPE_LO   = 17'd13;
    localparam pos_t OFS_IP_START  = 17'd14;
    localparam pos_t OFS_TOTLEN_HI = 17'd16;
    localparam pos_t OFS_TOTLEN_LO = 17'd17;
    localparam pos_t OFS_ARP_OP_HI = 17'd20;
    localparam pos_t OFS_ARP_OP_LO = 17'd21;
    localparam pos_t OFS_PROTO     = 17'd23;
    localparam pos_t OFS_ADDR_FIRST = 17'd26;
    localparam pos_t OFS_ADDR_LAST  = 17'd33;

    // segment byte positions
    localparam pos_t SEG_PORTS_END = 17'd3;
    localparam pos_t SEG_SEQ_END   = 17'd7;
    localparam pos_t SEG_ACK_END   = 17'd11;
    localparam pos_t SEG_FLAGS     = 17'd13;
    localparam pos_t SEG_WIN_HI    = 17'd14;
    localparam pos_t SEG_WIN_LO    = 17'd15;

    localparam logic [5:0] MIN_IP_HDR_BYTES = 6'd20;
    localparam logic [15:0] SUM_ALL_ONES    = 16'hFFFF;

    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'b0, t[16]};
    endfunction

    // pos 0 is the most significant byte
    function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = word;
        case (pos)
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
        endcase
        return r;
    endfunction

endpackage

// ===== design/eiphp_if.sv =====
// ----------------------------------------------------------------------------
// eiphp_if
// Valid/ready channels of the parser: frame bytes in, frame summaries out.
// ----------------------------------------------------------------------------
interface eiphp_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eiphp_summary_if import eiphp_pkg::*; ();
    logic          valid;
    logic          ready;
    eiphp_result_t res;

    modport source (output valid, output res, input ready);
    modport sink   (input valid, input res, output ready);
endinterface

// ===== design/eiphp_core.sv =====
// ----------------------------------------------------------------------------
// eiphp_core
// Per-frame parse state: byte offset, header fields and running checksums,
// updated once per byte; builds the frame summary on the last byte.
// ----------------------------------------------------------------------------
module eiphp_core
    import eiphp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output eiphp_result_t result
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [15:0]      ether_type_reg, ether_type_next;
    logic [3:0]       header_words_reg, header_words_next;
    logic [15:0]      total_length_reg, total_length_next;
    logic [15:0]      ip_sum_reg, ip_sum_next;
    logic [15:0]      seg_sum_reg, seg_sum_next;
    logic [7:0]       held_reg, held_next;
    logic [7:0]       protocol_reg, protocol_next;
    logic [31:0]      ports_reg, ports_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      ack_reg, ack_next;
    logic [23:0]      flags_window_reg, flags_window_next;
    logic [15:0]      arp_op_reg, arp_op_next;

    logic        taken;
    logic        is_arp;
    logic        is_ip;
    logic        past_mac;
    pos_t        o17;
    pos_t        seg_base;
    pos_t        s;
    logic        in_seg;
    logic [15:0] word;
    logic [3:0]  hw_eff;
    logic [5:0]  hb;
    logic [15:0] tl_eff;
    logic [15:0] len;

    // byte update
    always_comb
    begin
        offset_next       = offset_reg;
        ether_type_next   = ether_type_reg;
        header_words_next = header_words_reg;
        total_length_next = total_length_reg;
        ip_sum_next       = ip_sum_reg;
        seg_sum_next      = seg_sum_reg;
        held_next         = held_reg;
        protocol_next     = protocol_reg;
        ports_next        = ports_reg;
        seq_next          = seq_reg;
        ack_next          = ack_reg;
        flags_window_next = flags_window_reg;
        arp_op_next       = arp_op_reg;

        o17      = pos_t'(offset_reg);
        taken    = offset_reg < OFF_W'(MAX_FRAME_BYTES);
        word     = offset_reg[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
        is_arp   = ether_type_reg == ETH_ARP;
        is_ip    = ether_type_reg == ETH_IPV4;
        past_mac = o17 >= OFS_IP_START;

        hw_eff = (is_ip && o17 == OFS_IP_START) ? (data_byte[3:0] & IHL_MASK)
                                                : header_words_reg;
        hb     = {hw_eff, 2'b00};

        tl_eff = total_length_reg;
        if (is_ip && o17 == OFS_TOTLEN_HI)
        begin
            tl_eff = {data_byte, 8'h00};
        end
        else if (is_ip && o17 == OFS_TOTLEN_LO)
        begin
            tl_eff = {total_length_reg[15:8], data_byte};
        end

        seg_base = OFS_IP_START + pos_t'(hb);
        in_seg   = o17 >= seg_base;
        s        = o17 - seg_base;
        len      = tl_eff - {10'b0, hb};

        if (step && taken)
        begin
            offset_next = offset_reg + OFF_W'(1);
            held_next   = data_byte;

            if (o17 == OFS_TYPE_LO)
            begin
                ether_type_next = {held_reg, data_byte};
            end

            if (past_mac && is_arp)
            begin
                if (o17 == OFS_ARP_OP_HI)
                begin
                    arp_op_next = {data_byte, 8'h00};
                end
                if (o17 == OFS_ARP_OP_LO)
                begin
                    arp_op_next = {arp_op_reg[15:8], data_byte};
                end
            end

            if (past_mac && is_ip)
            begin
                header_words_next = hw_eff;
                total_length_next = tl_eff;

                if ((o17 - OFS_IP_START) < pos_t'(hb))
                begin
                    ip_sum_next = fold_add(ip_sum_reg, word);
                end

                if (o17 == OFS_PROTO)
                begin
                    protocol_next = data_byte;
                end

                // pseudo-header addresses, or segment bytes inside the length
                if ((o17 >= OFS_ADDR_FIRST && o17 <= OFS_ADDR_LAST) ||
                    (in_seg && hb >= MIN_IP_HDR_BYTES && s < {1'b0, len}))
                begin
                    seg_sum_next = fold_add(seg_sum_reg, word);
                end

                if (in_seg)
                begin
                    if (s <= SEG_PORTS_END)
                    begin
                        ports_next = put_byte(ports_reg, s[1:0], data_byte);
                    end
                    else if (s <= SEG_SEQ_END)
                    begin
                        seq_next = put_byte(seq_reg, s[1:0], data_byte);
                    end
                    else if (s <= SEG_ACK_END)
                    begin
                        ack_next = put_byte(ack_reg, s[1:0], data_byte);
                    end
                    else if (s == SEG_FLAGS)
                    begin
                        flags_window_next[23:16] = data_byte;
                    end
                    else if (s == SEG_WIN_HI)
                    begin
                        flags_window_next[15:8] = data_byte;
                    end
                    else if (s == SEG_WIN_LO)
                    begin
                        flags_window_next[7:0] = data_byte;
                    end
                end
            end
        end
    end

    // frame summary from the updated state
    logic        r_ip4;
    logic        r_tcp;
    logic        r_udp;
    logic [7:0]  r_proto;
    logic [5:0]  r_hb;
    logic [15:0] r_len;
    logic [15:0] r_fin;
    pos_t        r_n;

    always_comb
    begin
        r_n     = pos_t'(offset_next);
        r_ip4   = ether_type_next == ETH_IPV4;
        r_hb    = {header_words_next, 2'b00};
        r_len   = total_length_next - {10'b0, r_hb};
        r_proto = r_ip4 ? protocol_next : 8'h00;
        r_tcp   = r_ip4 && r_proto == PROTO_TCP;
        r_udp   = r_ip4 && r_proto == PROTO_UDP;
        r_fin   = fold_add(fold_add(seg_sum_next, {8'h00, PROTO_TCP}), r_len);

        if (ether_type_next == ETH_ARP)
        begin
            result.frame_kind = KIND_ARP;
        end
        else if (r_ip4)
        begin
            result.frame_kind = KIND_IPV4;
        end
        else
        begin
            result.frame_kind = KIND_UNKNOWN;
        end

        result.ip_protocol     = r_proto;
        result.ip_header_bytes = r_ip4 ? r_hb : 6'd0;
        result.ip_checksum_ok  = r_ip4 && (r_n >= OFS_IP_START + pos_t'(r_hb)) &&
                                 ip_sum_next == SUM_ALL_ONES;
        result.source_port     = (r_tcp || r_udp) ? ports_next[31:16] : 16'h0000;
        result.dest_port       = (r_tcp || r_udp) ? ports_next[15:0] : 16'h0000;
        result.tcp_flags       = r_tcp ? flags_window_next[23:16] : 8'h00;
        result.sequence_number = r_tcp ? seq_next : 32'h0;
        result.ack_number      = r_tcp ? ack_next : 32'h0;
        result.window_size     = r_tcp ? flags_window_next[15:0] : 16'h0000;
        result.tcp_checksum_ok = r_tcp && r_hb >= MIN_IP_HDR_BYTES &&
                                 (r_n >= OFS_IP_START + pos_t'(r_hb) + pos_t'(r_len)) &&
                                 r_fin == SUM_ALL_ONES;

        if (ether_type_next == ETH_ARP)
        begin
            result.type_code = arp_op_next;
        end
        else if (r_ip4 && r_proto == PROTO_ICMP)
        begin
            result.type_code = {8'h00, ports_next[31:24]};
        end
        else
        begin
            result.type_code = 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            total_length_reg <= '0;
            ip_sum_reg       <= '0;
            seg_sum_reg      <= '0;
            held_reg         <= '0;
            protocol_reg     <= '0;
            ports_reg        <= '0;
            seq_reg          <= '0;
            ack_reg          <= '0;
            flags_window_reg <= '0;
            arp_op_reg       <= '0;
        end
        else if (step && last_byte)
        begin
            // frame done, start clean
            offset_reg       <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            total_length_reg <= '0;
            ip_sum_reg       <= '0;
            seg_sum_reg      <= '0;
            held_reg         <= '0;
            protocol_reg     <= '0;
            ports_reg        <= '0;
            seq_reg          <= '0;
            ack_reg          <= '0;
            flags_window_reg <= '0;
            arp_op_reg       <= '0;
        end
        else
        begin
            offset_reg       <= offset_next;
            ether_type_reg   <= ether_type_next;
            header_words_reg <= header_words_next;
            total_length_reg <= total_length_next;
            ip_sum_reg       <= ip_sum_next;
            seg_sum_reg      <= seg_sum_next;
            held_reg         <= held_next;
            protocol_reg     <= protocol_next;
            ports_reg        <= ports_next;
            seq_reg          <= seq_next;
            ack_reg          <= ack_next;
            flags_window_reg <= flags_window_next;
            arp_op_reg       <= arp_op_next;
        end
    end

endmodule

// ===== design/ethernet_ipv4_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser_unit
// Byte-stream Ethernet / IPv4 / TCP / UDP / ICMP / ARP header parser with
// IPv4 header and TCP checksum checks.
//
// frame:   valid/ready sink, one frame byte per transfer starting at the first
//          destination MAC byte; last_byte marks the final byte of a frame.
// summary: valid/ready source, one summary transfer per frame, issued for the
//          transfer that carried last_byte; other bytes produce nothing.
// Throughput is one byte per cycle while no last byte waits on the summary;
//          the per-byte state update is a single pass of logic from the
//          input register into the parse state and the output register.
// A stalled summary holds in the output register; bytes of the next frame
//          keep flowing until that frame's last byte reaches the input
//          register, which then waits for the summary to be taken.
// Bytes beyond MAX_FRAME_BYTES in a frame are ignored except for the mark.
// Reset clears all parse state and empties both registers.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_parser_unit
    import eiphp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    eiphp_byte_if.sink        frame,
    eiphp_summary_if.source   summary
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          out_valid_reg;
    eiphp_result_t out_res_reg;
    eiphp_result_t core_result;
    logic          step;

    assign step        = in_valid_reg && (!in_last_reg || !out_valid_reg || summary.ready);
    assign frame.ready = !in_valid_reg || step;

    assign summary.valid = out_valid_reg;
    assign summary.res   = out_res_reg;

    eiphp_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (summary.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            in_byte_reg <= frame.data_byte;
            in_last_reg <= frame.last_byte;
        end
        if (step && in_last_reg)
        begin
            out_res_reg <= core_result;
        end
    end

endmodule

// ===== bench/ethernet_ipv4_header_parser_unit_test.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser_unit_test
// Streams Ethernet frames byte by byte into the parser and checks every frame
// summary field by field. A short table of hand-made frames covers the edge
// cases, then random frames follow: mostly well-formed ARP, TCP, UDP and ICMP
// with valid checksums and random content, plus truncated and broken frames.
// Expectations come from a byte-level parse model kept in this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ethernet_ipv4_header_parser_unit_test
    import eiphp_pkg::*;
();

    localparam int FRAME_CAP     = 2048;
    localparam int IDLE_PCT      = 23;
    localparam int RANDOM_BYTES  = 300;
    localparam int STEADY_FIRST  = 80;
    localparam int STEADY_LAST   = 260;
    localparam int SETTLE_CYCLES = 10;
    localparam int TABLE_ROWS    = 23;

    typedef struct {
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        int          seg_len;
        int          tot_len;
        bit          seal_ip;
        bit          seal_seg;
        int          cut;
        logic [15:0] opcode;
        bit          typed;
        logic [1:0]  want_kind;
        logic [15:0] want_code;
    } frame_plan_t;

    logic clk = 1'b0;
    logic rst_n;

    eiphp_byte_if    frame ();
    eiphp_summary_if summary ();

    ethernet_ipv4_header_parser_unit #(
        .MAX_FRAME_BYTES (FRAME_CAP)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame),
        .summary (summary)
    );

    always #10 clk = ~clk;

    // parse model state
    int          bytes_in;
    logic [15:0] eth_type;
    logic [3:0]  ihl;
    logic [15:0] ip_len;
    logic [15:0] hdr_sum;
    logic [15:0] seg_sum;
    logic [7:0]  prev_byte;
    logic [7:0]  proto_byte;
    logic [31:0] port_word;
    logic [31:0] seq_word;
    logic [31:0] ack_word;
    logic [7:0]  flag_byte;
    logic [15:0] win_word;
    logic [15:0] arp_op;

    eiphp_result_t expected_summaries [$];

    int errors;
    int bytes_sent;
    int frames_checked;
    int arp_seen;
    int ipv4_seen;
    int other_seen;
    int ip_sum_good;
    int tcp_sum_good;
    bit steady;

    frame_plan_t directed [TABLE_ROWS] = '{
        // one byte, nothing parsed
        '{16'h0000, 4'd0, 8'h00, 0, -1, 1'b0, 1'b0, 1, 16'h0000, 1'b1, KIND_UNKNOWN, 16'h0000},
        // arp opcode extremes, then a frame cut before the opcode
        '{ETH_ARP, 4'd0, 8'h00, 28, -1, 1'b0, 1'b0, 0, 16'hFFFF, 1'b1, KIND_ARP, 16'hFFFF},
        '{ETH_ARP, 4'd0, 8'h00, 28, -1, 1'b0, 1'b0, 0, 16'h0001, 1'b1, KIND_ARP, 16'h0001},
        '{ETH_ARP, 4'd0, 8'h00, 28, -1, 1'b0, 1'b0, 20, 16'hABCD, 1'b1, KIND_ARP, 16'h0000},
        // unknown ethertypes
        '{16'hFFFF, 4'd5, 8'h00, 6, -1, 1'b0, 1'b0, 0, 16'h0000, 1'b1, KIND_UNKNOWN, 16'h0000},
        '{16'h0801, 4'd5, 8'h00, 6, -1, 1'b0, 1'b0, 0, 16'h0000, 1'b1, KIND_UNKNOWN, 16'h0000},
        // ipv4 frame that ends right after the ethertype
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b1, 1'b1, 14, 16'h0000, 1'b1, KIND_IPV4, 16'h0000},
        // well-formed tcp: minimal header, longest header, odd segment length
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b1, 1'b1, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd15, PROTO_TCP, 24, -1, 1'b1, 1'b1, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, PROTO_TCP, 33, -1, 1'b1, 1'b1, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        // bad header sum, bad segment sum
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b0, 1'b1, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        // udp, icmp, other protocols
        '{ETH_IPV4, 4'd5, PROTO_UDP, 12, -1, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, PROTO_ICMP, 8, -1, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, 8'hFF, 10, -1, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, 8'h00, 10, -1, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        // ihl of zero and below five
        '{ETH_IPV4, 4'd0, PROTO_TCP, 30, -1, 1'b1, 1'b1, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd4, PROTO_TCP, 30, -1, 1'b1, 1'b1, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        // total length below the header, total length at its maximum
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, 10, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, 65535, 1'b1, 1'b0, 0, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        // frame ends inside the ip header, then inside the tcp span
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b1, 1'b1, 25, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b1, 1'b1, 44, 16'h0000, 1'b0, KIND_IPV4, 16'h0000},
        // short tcp segment with link padding
        '{ETH_IPV4, 4'd5, PROTO_TCP, 8, -1, 1'b1, 1'b0, 60, 16'h0000, 1'b0, KIND_IPV4, 16'h0000}
    };

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + 16'(t[16]);
    endfunction

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    task automatic clear_parse();
        bytes_in   = 0;
        eth_type   = 16'h0000;
        ihl        = 4'd0;
        ip_len     = 16'h0000;
        hdr_sum    = 16'h0000;
        seg_sum    = 16'h0000;
        prev_byte  = 8'h00;
        proto_byte = 8'h00;
        port_word  = 32'h0;
        seq_word   = 32'h0;
        ack_word   = 32'h0;
        flag_byte  = 8'h00;
        win_word   = 16'h0000;
        arp_op     = 16'h0000;
    endtask

    task automatic parse_byte(input logic [7:0] b, input bit last, output bit done,
                              output eiphp_result_t r);
        int          o;
        int          hb;
        int          pos;
        int          seg_len;
        logic [15:0] w;
        logic [15:0] fin;
        bit          v4;
        bit          tcp;
        bit          udp;
        done = 1'b0;
        r = '0;
        o = bytes_in;
        if (bytes_in < FRAME_CAP)
        begin
            w = o[0] ? {8'h00, b} : {b, 8'h00};
            if (o == 13)
                eth_type = {prev_byte, b};
            if (o >= 14 && eth_type == ETH_ARP)
            begin
                if (o == 20)
                    arp_op[15:8] = b;
                if (o == 21)
                    arp_op[7:0] = b;
            end
            if (o >= 14 && eth_type == ETH_IPV4)
            begin
                if (o == 14)
                    ihl = b[3:0];
                hb = 4 * ihl;
                if (o - 14 < hb)
                    hdr_sum = oc_add(hdr_sum, w);
                if (o == 16)
                    ip_len = {b, 8'h00};
                if (o == 17)
                    ip_len[7:0] = b;
                if (o == 23)
                    proto_byte = b;
                if (o >= 26 && o <= 33)
                    seg_sum = oc_add(seg_sum, w);
                if (o >= 14 + hb)
                begin
                    pos = o - 14 - hb;
                    seg_len = (int'(ip_len) - hb) & 'hFFFF;
                    if (hb >= MIN_IP_HDR_BYTES && pos < seg_len)
                        seg_sum = oc_add(seg_sum, w);
                    if (pos <= 3)
                        port_word[31 - 8 * pos -: 8] = b;
                    else if (pos <= 7)
                        seq_word[63 - 8 * pos -: 8] = b;
                    else if (pos <= 11)
                        ack_word[95 - 8 * pos -: 8] = b;
                    else if (pos == 13)
                        flag_byte = b;
                    else if (pos == 14)
                        win_word[15:8] = b;
                    else if (pos == 15)
                        win_word[7:0] = b;
                end
            end
            prev_byte = b;
            bytes_in++;
        end
        if (last)
        begin
            done = 1'b1;
            hb = 4 * ihl;
            seg_len = (int'(ip_len) - hb) & 'hFFFF;
            v4 = (eth_type == ETH_IPV4);
            tcp = v4 && proto_byte == PROTO_TCP;
            udp = v4 && proto_byte == PROTO_UDP;
            r.frame_kind = (eth_type == ETH_ARP) ? KIND_ARP : v4 ? KIND_IPV4 : KIND_UNKNOWN;
            r.ip_protocol = v4 ? proto_byte : 8'h00;
            r.ip_header_bytes = v4 ? 6'(hb) : 6'd0;
            r.ip_checksum_ok = v4 && bytes_in >= 14 + hb && hdr_sum == SUM_ALL_ONES;
            if (tcp || udp)
            begin
                r.source_port = port_word[31:16];
                r.dest_port = port_word[15:0];
            end
            if (tcp)
            begin
                r.tcp_flags = flag_byte;
                r.sequence_number = seq_word;
                r.ack_number = ack_word;
                r.window_size = win_word;
                fin = oc_add(oc_add(seg_sum, {8'h00, PROTO_TCP}), seg_len[15:0]);
                r.tcp_checksum_ok = hb >= MIN_IP_HDR_BYTES && bytes_in >= 14 + hb + seg_len
                                    && fin == SUM_ALL_ONES;
            end
            if (eth_type == ETH_ARP)
                r.type_code = arp_op;
            else if (v4 && proto_byte == PROTO_ICMP)
                r.type_code = {8'h00, port_word[31:24]};
            clear_parse();
        end
    endtask

    task automatic send_frame(input frame_plan_t p);
        logic [7:0]    img [4096];
        logic [15:0]   acc;
        logic [15:0]   tl;
        int            hb;
        int            nat;
        int            span;
        int            base;
        int            len;
        int            i;
        bit            done;
        eiphp_result_t guess;
        hb = 4 * p.ihl;
        nat = 14 + ((p.etype == ETH_IPV4) ? hb : 0) + p.seg_len;
        len = (p.cut > 0) ? p.cut : nat;
        span = (len > nat) ? len : nat;
        if (span < 34)
            span = 34;
        for (i = 0; i < span; i++)
            img[i] = 8'($urandom);
        img[12] = p.etype[15:8];
        img[13] = p.etype[7:0];
        if (p.etype == ETH_ARP)
        begin
            img[20] = p.opcode[15:8];
            img[21] = p.opcode[7:0];
        end
        if (p.etype == ETH_IPV4)
        begin
            base = 14 + hb;
            tl = (p.tot_len < 0) ? 16'(hb + p.seg_len) : 16'(p.tot_len);
            img[14] = {img[14][7:4], p.ihl};
            img[16] = tl[15:8];
            img[17] = tl[7:0];
            img[23] = p.proto;
            // tcp sum over pseudo-header and segment
            if (p.seal_seg && p.proto == PROTO_TCP && hb >= MIN_IP_HDR_BYTES && p.seg_len >= 18)
            begin
                img[base + 16] = 8'h00;
                img[base + 17] = 8'h00;
                acc = {8'h00, PROTO_TCP};
                for (i = 26; i < 34; i += 2)
                    acc = oc_add(acc, {img[i], img[i + 1]});
                for (i = 0; i < p.seg_len; i += 2)
                    acc = oc_add(acc, {img[base + i],
                                       ((i + 1 < p.seg_len) ? img[base + i + 1] : 8'h00)});
                acc = ~oc_add(acc, tl - 16'(hb));
                img[base + 16] = acc[15:8];
                img[base + 17] = acc[7:0];
            end
            if (p.seal_ip && hb >= 12)
            begin
                img[24] = 8'h00;
                img[25] = 8'h00;
                acc = 16'h0000;
                for (i = 14; i < base; i += 2)
                    acc = oc_add(acc, {img[i], img[i + 1]});
                acc = ~acc;
                img[24] = acc[15:8];
                img[25] = acc[7:0];
            end
        end
        for (i = 0; i < len; i++)
        begin
            while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                frame.valid <= 1'b0;
                @(posedge clk);
            end
            frame.valid <= 1'b1;
            frame.data_byte <= img[i];
            frame.last_byte <= (i == len - 1);
            @(posedge clk);
            while (!frame.ready)
                @(posedge clk);
            bytes_sent++;
            parse_byte(img[i], i == len - 1, done, guess);
            if (done)
            begin
                if (p.typed)
                begin
                    guess = '0;
                    guess.frame_kind = p.want_kind;
                    guess.type_code = p.want_code;
                end
                expected_summaries.push_back(guess);
            end
        end
    endtask

    task automatic drain_summaries();
        frame.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_summaries.size() != 0);
    endtask

    // frame source
    initial
    begin
        frame_plan_t p;
        int          i;
        int          nat;
        int          pick;
        int          rnd_bytes;
        int          rnd_frames;
        rst_n <= 1'b0;
        frame.valid <= 1'b0;
        frame.data_byte <= 8'h00;
        frame.last_byte <= 1'b0;
        errors = 0;
        bytes_sent = 0;
        steady = 1'b0;
        clear_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < TABLE_ROWS; i++)
            send_frame(directed[i]);
        drain_summaries();
        rnd_bytes = 0;
        rnd_frames = 0;
        while (rnd_bytes < RANDOM_BYTES)
        begin
            steady = (rnd_bytes >= STEADY_FIRST && rnd_bytes < STEADY_LAST);
            if (rnd_frames == 2)
                drain_summaries();
            p = '{ETH_IPV4, 4'd5, PROTO_TCP, 20, -1, 1'b1, 1'b1, 0, 16'h0000, 1'b0,
                  KIND_IPV4, 16'h0000};
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                p.ihl = 4'($urandom_range(5, 15));
            if (pick < 40)
                p.seg_len = $urandom_range(20, 60);
            else if (pick < 55)
            begin
                p.proto = PROTO_UDP;
                p.seg_len = $urandom_range(8, 40);
            end
            else if (pick < 65)
            begin
                p.proto = PROTO_ICMP;
                p.seg_len = $urandom_range(8, 40);
            end
            else if (pick < 73)
            begin
                p.proto = 8'($urandom);
                p.seg_len = $urandom_range(0, 40);
            end
            else if (pick < 81)
            begin
                p.etype = ETH_ARP;
                p.seg_len = 28;
                p.opcode = 16'($urandom);
            end
            else if (pick < 86)
            begin
                p.etype = 16'($urandom);
                p.seg_len = $urandom_range(0, 50);
            end
            else
            begin
                // malformed ipv4
                p.ihl = 4'($urandom);
                p.proto = $urandom_range(0, 1) ? PROTO_TCP : 8'($urandom);
                p.seg_len = $urandom_range(0, 50);
                p.seal_ip = 1'($urandom);
                p.seal_seg = 1'($urandom);
                if ($urandom_range(0, 1))
                    p.tot_len = $urandom_range(0, 65535);
            end
            nat = 14 + ((p.etype == ETH_IPV4) ? 4 * p.ihl : 0) + p.seg_len;
            case ($urandom_range(0, 9))
                0:       p.cut = $urandom_range(1, nat);
                1, 2:    p.cut = nat + $urandom_range(1, 12);
                default: p.cut = 0;
            endcase
            i = bytes_sent;
            send_frame(p);
            rnd_bytes += bytes_sent - i;
            rnd_frames++;
        end
        steady = 1'b0;
        drain_summaries();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("checked %0d frame summaries over %0d bytes: %0d ARP, %0d IPv4, %0d other",
                 frames_checked, bytes_sent, arp_seen, ipv4_seen, other_seen);
        $display("good header sums in %0d frames, good TCP sums in %0d frames",
                 ip_sum_good, tcp_sum_good);
        if (errors == 0)
            $display("ethernet_ipv4_header_parser_unit_test: clean");
        else
            $display("ethernet_ipv4_header_parser_unit_test: errors");
        $finish;
    end

    // summary sink and checker
    initial
    begin
        eiphp_result_t want;
        eiphp_result_t got;
        frames_checked = 0;
        arp_seen = 0;
        ipv4_seen = 0;
        other_seen = 0;
        ip_sum_good = 0;
        tcp_sum_good = 0;
        summary.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && summary.valid && summary.ready)
            begin
                got = summary.res;
                if (expected_summaries.size() == 0)
                begin
                    $error("summary transfer with no frame pending");
                    errors++;
                end
                else
                begin
                    want = expected_summaries.pop_front();
                    errors += field_diff("frame_kind", 32'(want.frame_kind),
                                         32'(got.frame_kind));
                    errors += field_diff("ip_protocol", 32'(want.ip_protocol),
                                         32'(got.ip_protocol));
                    errors += field_diff("ip_header_bytes", 32'(want.ip_header_bytes),
                                         32'(got.ip_header_bytes));
                    errors += field_diff("ip_checksum_ok", 32'(want.ip_checksum_ok),
                                         32'(got.ip_checksum_ok));
                    errors += field_diff("source_port", 32'(want.source_port),
                                         32'(got.source_port));
                    errors += field_diff("dest_port", 32'(want.dest_port),
                                         32'(got.dest_port));
                    errors += field_diff("tcp_flags", 32'(want.tcp_flags),
                                         32'(got.tcp_flags));
                    errors += field_diff("sequence_number", want.sequence_number,
                                         got.sequence_number);
                    errors += field_diff("ack_number", want.ack_number, got.ack_number);
                    errors += field_diff("window_size", 32'(want.window_size),
                                         32'(got.window_size));
                    errors += field_diff("tcp_checksum_ok", 32'(want.tcp_checksum_ok),
                                         32'(got.tcp_checksum_ok));
                    errors += field_diff("type_code", 32'(want.type_code),
                                         32'(got.type_code));
                    frames_checked++;
                    if (want.frame_kind == KIND_ARP)
                        arp_seen++;
                    else if (want.frame_kind == KIND_IPV4)
                        ipv4_seen++;
                    else
                        other_seen++;
                    if (want.ip_checksum_ok)
                        ip_sum_good++;
                    if (want.tcp_checksum_ok)
                        tcp_sum_good++;
                end
            end
            summary.ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("ethernet_ipv4_header_parser_unit_test: errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/eiphp_pkg.sv
design/eiphp_if.sv
design/eiphp_core.sv
design/ethernet_ipv4_header_parser_unit.sv
bench/ethernet_ipv4_header_parser_unit_test.sv
